[src/gbw_pkg.sv]
`default_nettype none

package gbw_pkg;

	// Width of the running column total. The output always shows its low 16 bits.
	localparam int TOTAL_BITS = 16;

	localparam logic [20:0] VS16_CP = 21'h00FE0F;
	localparam logic [20:0] VS15_CP = 21'h00FE0E;
	localparam logic [20:0] ZWJ_CP  = 21'h00200D;

	localparam logic [3:0] C_OTHER   = 4'd0;
	localparam logic [3:0] C_CR      = 4'd1;
	localparam logic [3:0] C_LF      = 4'd2;
	localparam logic [3:0] C_CONTROL = 4'd3;
	localparam logic [3:0] C_EXTEND  = 4'd4;
	localparam logic [3:0] C_ZWJ     = 4'd5;
	localparam logic [3:0] C_RI      = 4'd6;
	localparam logic [3:0] C_PREPEND = 4'd7;
	localparam logic [3:0] C_SPACING = 4'd8;
	localparam logic [3:0] C_L       = 4'd9;
	localparam logic [3:0] C_V       = 4'd10;
	localparam logic [3:0] C_T       = 4'd11;
	localparam logic [3:0] C_LV      = 4'd12;
	localparam logic [3:0] C_LVT     = 4'd13;

	localparam logic [1:0] CC_NONE      = 2'd0;
	localparam logic [1:0] CC_CONSONANT = 2'd1;
	localparam logic [1:0] CC_LINKER    = 2'd2;
	localparam logic [1:0] CC_EXTEND    = 2'd3;

	// Bit positions in the width mark vector.
	localparam int M_VS16 = 0;
	localparam int M_VS15 = 1;
	localparam int M_ZWJ  = 2;
	localparam int M_PICT = 3;

	// Queue between the front and the back end.
	localparam logic [1:0] QUEUE_DEPTH = 2'd2;

	// One classified code point, as the front end hands it to the back end.
	typedef struct packed {
		logic [3:0] cls;
		logic       pict;
		logic [1:0] cc;
		logic [3:0] marks;
		logic [1:0] lead_width;
		logic       eot;
	} gbw_item_t;

	function automatic logic is_ctl(input logic [3:0] g);
		is_ctl = (g == C_CONTROL) || (g == C_CR) || (g == C_LF);
	endfunction

endpackage

`default_nettype wire

[src/gbw_front.sv]
`default_nettype none

// Front end: normalizes the break class and works out the width marks and
// the width a cluster would have if it opened with this code point.
module gbw_front (
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [23:0]       s_axis_tdata,
	input  wire logic [7:0]        s_axis_tuser,
	input  wire logic              s_axis_tlast,
	output logic                   item_valid,
	input  wire logic              item_ready,
	output gbw_pkg::gbw_item_t     item
);

	logic [20:0] cp;
	logic [3:0]  raw_cls;
	logic [3:0]  cls;
	logic        wide;

	always_comb begin
		cp      = s_axis_tdata[20:0];
		raw_cls = s_axis_tuser[3:0];
		wide    = s_axis_tuser[7];
		cls     = (raw_cls > gbw_pkg::C_LVT) ? gbw_pkg::C_OTHER : raw_cls;

		item.cls  = cls;
		item.pict = s_axis_tuser[4];
		item.cc   = s_axis_tuser[6:5];
		item.eot  = s_axis_tlast;

		item.marks                 = 4'b0000;
		item.marks[gbw_pkg::M_VS16] = (cp == gbw_pkg::VS16_CP);
		item.marks[gbw_pkg::M_VS15] = (cp == gbw_pkg::VS15_CP);
		item.marks[gbw_pkg::M_ZWJ]  = (cp == gbw_pkg::ZWJ_CP);
		item.marks[gbw_pkg::M_PICT] = s_axis_tuser[4];

		if (gbw_pkg::is_ctl(cls) || cls == gbw_pkg::C_EXTEND || cls == gbw_pkg::C_ZWJ) begin
			item.lead_width = 2'd0;
		end else if (wide) begin
			item.lead_width = 2'd2;
		end else begin
			item.lead_width = 2'd1;
		end
	end

	assign item_valid    = s_axis_tvalid;
	assign s_axis_tready = item_ready;

endmodule

`default_nettype wire

[src/gbw_queue.sv]
`default_nettype none

// Two-entry queue between the front and the back end.
module gbw_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_valid,
	output logic                    wr_ready,
	input  wire gbw_pkg::gbw_item_t wr_item,
	output logic                    rd_valid,
	input  wire logic               rd_ready,
	output gbw_pkg::gbw_item_t      rd_item,
	output logic [1:0]              fill
);

	gbw_pkg::gbw_item_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign wr_ready = (count_q != gbw_pkg::QUEUE_DEPTH);
	assign rd_valid = (count_q != 2'd0);
	assign rd_item  = slot_q[rd_ptr_q];
	assign fill     = count_q;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

[src/gbw_back.sv]
`default_nettype none

// Back end: break rules on the stored previous class, cluster width and the
// running total, with the result held in an output register.
module gbw_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire gbw_pkg::gbw_item_t item,
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	output logic [23:0]             m_axis_tdata
);

	localparam int TB = gbw_pkg::TOTAL_BITS;

	logic          in_text_q;
	logic [3:0]    prev_q;
	logic          ri_odd_q;
	logic          emoji_run_q;
	logic          joiner_valid_q;
	logic          conj_seen_q;
	logic          linker_seen_q;
	logic [1:0]    first_width_q;
	logic [1:0]    pos_q;
	logic          first_ri_q;
	logic          flag_pair_q;
	logic [3:0]    marks_q;
	logic [TB-1:0] total_q;

	logic          out_valid_q;
	logic          start_q;
	logic          closed_q;
	logic [1:0]    closed_w_q;
	logic [1:0]    final_w_q;
	logic [15:0]   total_out_q;

	logic          ri_odd_d;
	logic          emoji_run_d;
	logic          joiner_valid_d;
	logic          conj_seen_d;
	logic          linker_seen_d;
	logic [1:0]    first_width_d;
	logic [1:0]    pos_d;
	logic          first_ri_d;
	logic          flag_pair_d;
	logic [3:0]    marks_d;
	logic [TB-1:0] total_d;

	logic          brk;
	logic          start;
	logic          closed;
	logic [1:0]    closed_w;
	logic [1:0]    final_w;
	logic [3:0]    g;
	logic [3:0]    g1;
	logic          cs_in;
	logic          ls_in;
	logic [TB-1:0] base;
	logic [TB:0]   sum;
	logic          take;

	function automatic logic [1:0] width_of(input logic [3:0] m, input logic fp,
		input logic [1:0] fw);
		if (m[gbw_pkg::M_VS16]) begin
			width_of = 2'd2;
		end else if (m[gbw_pkg::M_VS15]) begin
			width_of = 2'd1;
		end else if (fp) begin
			width_of = 2'd2;
		end else if (m[gbw_pkg::M_ZWJ] && m[gbw_pkg::M_PICT]) begin
			width_of = 2'd2;
		end else begin
			width_of = fw;
		end
	endfunction

	assign item_ready = !out_valid_q || m_axis_tready;
	assign take       = item_valid && item_ready;

	always_comb begin
		g  = item.cls;
		g1 = prev_q;

		// Break rules GB3 to GB999, first match wins.
		if (g1 == gbw_pkg::C_CR && g == gbw_pkg::C_LF) begin
			brk = 1'b0;
		end else if (gbw_pkg::is_ctl(g1) || gbw_pkg::is_ctl(g)) begin
			brk = 1'b1;
		end else if (g1 == gbw_pkg::C_L && (g == gbw_pkg::C_L || g == gbw_pkg::C_V ||
			g == gbw_pkg::C_LV || g == gbw_pkg::C_LVT)) begin
			brk = 1'b0;
		end else if ((g1 == gbw_pkg::C_LV || g1 == gbw_pkg::C_V) &&
			(g == gbw_pkg::C_V || g == gbw_pkg::C_T)) begin
			brk = 1'b0;
		end else if ((g1 == gbw_pkg::C_LVT || g1 == gbw_pkg::C_T) && g == gbw_pkg::C_T) begin
			brk = 1'b0;
		end else if (g == gbw_pkg::C_EXTEND || g == gbw_pkg::C_ZWJ ||
			g == gbw_pkg::C_SPACING || g1 == gbw_pkg::C_PREPEND) begin
			brk = 1'b0;
		end else if (conj_seen_q && linker_seen_q && item.cc == gbw_pkg::CC_CONSONANT) begin
			brk = 1'b0;
		end else if (g1 == gbw_pkg::C_ZWJ && joiner_valid_q && item.pict) begin
			brk = 1'b0;
		end else if (g1 == gbw_pkg::C_RI && g == gbw_pkg::C_RI && ri_odd_q) begin
			brk = 1'b0;
		end else begin
			brk = 1'b1;
		end

		start    = !in_text_q || brk;
		closed   = in_text_q && brk;
		closed_w = closed ? width_of(marks_q, flag_pair_q, first_width_q) : 2'd0;

		// A new cluster starts the conjunct run from nothing.
		cs_in = start ? 1'b0 : conj_seen_q;
		ls_in = start ? 1'b0 : linker_seen_q;
		if (item.cc == gbw_pkg::CC_CONSONANT) begin
			conj_seen_d   = 1'b1;
			linker_seen_d = 1'b0;
		end else if (cs_in && (item.cc == gbw_pkg::CC_LINKER ||
			item.cc == gbw_pkg::CC_EXTEND)) begin
			conj_seen_d   = 1'b1;
			linker_seen_d = ls_in || (item.cc == gbw_pkg::CC_LINKER);
		end else begin
			conj_seen_d   = 1'b0;
			linker_seen_d = 1'b0;
		end

		if (start) begin
			ri_odd_d       = (g == gbw_pkg::C_RI);
			emoji_run_d    = item.pict;
			joiner_valid_d = 1'b0;
			first_width_d  = item.lead_width;
			pos_d          = 2'd0;
			first_ri_d     = (g == gbw_pkg::C_RI);
			flag_pair_d    = 1'b0;
			marks_d        = item.marks;
		end else begin
			ri_odd_d       = (g == gbw_pkg::C_RI) ? !ri_odd_q : 1'b0;
			joiner_valid_d = (g == gbw_pkg::C_ZWJ) ? emoji_run_q : 1'b0;
			emoji_run_d    = item.pict || (emoji_run_q && g == gbw_pkg::C_EXTEND);
			first_width_d  = first_width_q;
			first_ri_d     = first_ri_q;
			// The second indicator of a flag pair adds no marks.
			if (pos_q == 2'd0 && first_ri_q && g == gbw_pkg::C_RI) begin
				flag_pair_d = 1'b1;
				marks_d     = marks_q;
			end else begin
				flag_pair_d = flag_pair_q;
				marks_d     = marks_q | item.marks;
			end
			pos_d = (pos_q == 2'd3) ? pos_q : pos_q + 2'd1;
		end

		final_w = item.eot ? width_of(marks_d, flag_pair_d, first_width_d) : 2'd0;

		// Saturating once on the combined sum gives the same result as
		// saturating after each of the two additions.
		base    = in_text_q ? total_q : '0;
		sum     = {1'b0, base} + {{(TB - 1){1'b0}}, closed_w} + {{(TB - 1){1'b0}}, final_w};
		total_d = sum[TB] ? {TB{1'b1}} : sum[TB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_text_q      <= 1'b0;
			prev_q         <= gbw_pkg::C_OTHER;
			ri_odd_q       <= 1'b0;
			emoji_run_q    <= 1'b0;
			joiner_valid_q <= 1'b0;
			conj_seen_q    <= 1'b0;
			linker_seen_q  <= 1'b0;
			first_width_q  <= 2'd0;
			pos_q          <= 2'd0;
			first_ri_q     <= 1'b0;
			flag_pair_q    <= 1'b0;
			marks_q        <= 4'b0000;
			total_q        <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (take) begin
				in_text_q      <= !item.eot;
				prev_q         <= g;
				ri_odd_q       <= ri_odd_d;
				emoji_run_q    <= emoji_run_d;
				joiner_valid_q <= joiner_valid_d;
				conj_seen_q    <= conj_seen_d;
				linker_seen_q  <= linker_seen_d;
				first_width_q  <= first_width_d;
				pos_q          <= pos_d;
				first_ri_q     <= first_ri_d;
				flag_pair_q    <= flag_pair_d;
				marks_q        <= marks_d;
				total_q        <= total_d;
				out_valid_q    <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			start_q     <= start;
			closed_q    <= closed;
			closed_w_q  <= closed_w;
			final_w_q   <= final_w;
			total_out_q <= 16'(total_d);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, total_out_q, final_w_q, closed_w_q, closed_q, start_q};

endmodule

`default_nettype wire

[src/grapheme_segment_width.sv]
`default_nettype none

// Channel   Dir  Signals                Item contents
// s_axis    in   tvalid tready tdata    tdata: code point; tuser: properties
//                tuser tlast            tlast: last code point of the text
// m_axis    out  tvalid tready tdata    tdata: boundary flags, widths, total
//
// One code point enters per cycle while s_axis_tready is high. Its result is
// registered in the queue and then in the back end's output register before it
// is offered on m_axis. The back end keeps the rate because its break rules and
// width choice read only one stored previous class and a few state bits.
// Reset is asynchronous and clears all control and segmentation state, so the
// first code point after reset starts a new text with a column total of zero.
// A stall on the output holds the result register; the two-entry queue keeps
// taking code points until it fills, and only then drops s_axis_tready.
module grapheme_segment_width (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [20:0] code_point, [23:21] zero
	input  wire logic [23:0] s_axis_tdata,
	// [3:0] break_class, [4] pictographic, [6:5] conjunct_class, [7] east_asian_wide
	input  wire logic [7:0]  s_axis_tuser,
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [0] cluster_start, [1] closed_valid, [3:2] closed_width, [5:4] final_width,
	// [21:6] total_width, [23:22] zero
	output logic [23:0]      m_axis_tdata
);

	// Classified items travel from the front end through the queue.
	gbw_pkg::gbw_item_t front_item;
	gbw_pkg::gbw_item_t back_item;
	logic               front_valid;
	logic               front_ready;
	logic               back_valid;
	logic               back_ready;
	logic [1:0]         queue_fill;

	// The front end only classifies; it has no state of its own.
	gbw_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.item_valid    (front_valid),
		.item_ready    (front_ready),
		.item          (front_item)
	);

	// The queue lets the front end keep accepting while the output stalls.
	gbw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.wr_item  (front_item),
		.rd_valid (back_valid),
		.rd_ready (back_ready),
		.rd_item  (back_item),
		.fill     (queue_fill)
	);

	// The back end holds all segmentation state and the output register.
	gbw_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (back_valid),
		.item_ready    (back_ready),
		.item          (back_item),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// The queue never holds more items than it has slots.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		queue_fill <= gbw_pkg::QUEUE_DEPTH)
		else $error("queue fill above depth");

	// Input is refused only when the queue is full.
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> queue_fill == gbw_pkg::QUEUE_DEPTH)
		else $error("input stalled with room in the queue");

	// A cluster can only close where a new one starts.
	a_close_start: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
		else $error("cluster closed without a new cluster start");

	// No cluster is ever three columns wide.
	a_width_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[3:2] != 2'd3 && m_axis_tdata[5:4] != 2'd3)
		else $error("cluster width out of range");

endmodule

`default_nettype wire
